>>> rtl/bta_pkg.sv
package bta_pkg;

  // default pool size, largest power of two not above it is used
  localparam int unsigned DefTotalPages = 1024;

  localparam int unsigned PagesW  = 11;
  localparam int unsigned OffsetW = 10;

  typedef enum logic {
    KindAlloc = 1'b0,
    KindFree  = 1'b1
  } bta_kind_e;

  typedef struct packed {
    bta_kind_e            kind;
    logic [PagesW-1:0]    pages;
    logic [OffsetW-1:0]   offset;
  } bta_in_t;

  typedef struct packed {
    logic                 ok;
    logic [OffsetW-1:0]   block_offset;
    logic [PagesW-1:0]    block_pages;
    logic [PagesW-1:0]    free_count;
  } bta_out_t;

endpackage

>>> rtl/buddy_tree_page_allocator.sv
// Buddy page allocator. Each transaction either allocates (kind = alloc) a
// block of pages, its count rounded up to a power of two, or frees a block
// given by offset and page count. The pool is the largest power of two not
// above TOTAL_PAGES; a tree memory of 2*pool entries holds, for every node,
// the largest free block in its subtree. An allocation walks down from the
// root one level per cycle (left child preferred), marks the node used and
// walks back up one level per cycle refreshing ancestors; a free reads the
// node at the freed size's level, restores it and walks up merging buddies.
// The walk rate is set by the single read port of the tree memory and the
// shared merge unit, one level per cycle; a refused request goes to its
// result without walking the tree.
// Input ready is low while a transaction is in progress. The result sits in
// an output register, so a new transaction may be accepted while it waits.
// After reset the tree memory is initialised by a sweep over nodes 1 to
// 2*pool-1, during which no transaction is accepted.
module buddy_tree_page_allocator #(
  parameter int unsigned TOTAL_PAGES = bta_pkg::DefTotalPages
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bta_pkg::bta_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bta_pkg::bta_out_t out_data_o
);

  // pool geometry
  localparam int unsigned PoolLog = $clog2(TOTAL_PAGES + 1) - 1;
  localparam int unsigned Pool    = 1 << PoolLog;
  localparam int unsigned NodeW   = PoolLog + 1;
  localparam int unsigned AddrW   = PoolLog + 1;
  localparam int unsigned Depth   = 2 * Pool;
  localparam int unsigned CalcW   = (PoolLog + 2 > 13) ? PoolLog + 2 : 13;
  localparam int unsigned OffW    = (PoolLog > bta_pkg::OffsetW) ? PoolLog : bta_pkg::OffsetW;
  localparam int unsigned LvlW    = $clog2(CalcW + 1);

  typedef enum logic [7:0] {
    StInit    = 8'b0000_0001,
    StIdle    = 8'b0000_0010,
    StCheck   = 8'b0000_0100,
    StDesc    = 8'b0000_1000,
    StFreeChk = 8'b0001_0000,
    StMark    = 8'b0010_0000,
    StUp      = 8'b0100_0000,
    StDone    = 8'b1000_0000
  } state_e;

  // log2 of the page count rounded up to a power of two, zero counts as one
  function automatic logic [3:0] size_log(input logic [bta_pkg::PagesW-1:0] pages);
    logic [3:0] lg;
    lg = 4'd11;
    for (int k = 11; k >= 0; k--) begin
      if ((12'd1 << k) >= {1'b0, pages}) begin
        lg = 4'(k);
      end
    end
    return lg;
  endfunction

  state_e                 state_q, state_d;
  bta_pkg::bta_kind_e     kind_q, kind_d;
  logic [LvlW-1:0]        klog_q, klog_d;     // log2 of the rounded size
  logic [bta_pkg::OffsetW-1:0] offset_q, offset_d;
  logic [AddrW-1:0]       node_q, node_d;     // heap index, root is 1
  logic [LvlW-1:0]        lvl_q, lvl_d;       // log2 of the current node's span
  logic [OffW-1:0]        blk_off_q, blk_off_d;
  logic [NodeW-1:0]       cur_val_q, cur_val_d;
  logic                   ok_q, ok_d;
  logic [NodeW-1:0]       free_q, free_d;
  logic [NodeW-1:0]       root_q, root_d;     // copy of the root entry
  logic                   out_valid_q, out_valid_d;
  bta_pkg::bta_out_t      out_q, out_d;

  // tree memory port
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [NodeW-1:0]       ram_wdata;
  logic [AddrW-1:0]       ram_raddr;
  logic [NodeW-1:0]       ram_rdata;

  // merge unit
  logic [NodeW-1:0]       alu_left, alu_right, alu_parent_size, alu_merged;
  logic                   alu_left_fits;

  logic [CalcW-1:0]       size_c;
  logic [CalcW-1:0]       pool_c;
  logic [CalcW-1:0]       offset_c;
  logic [CalcW-1:0]       free_node_c;
  logic [CalcW-1:0]       free_sum_c;
  logic                   alloc_ok_c;
  logic                   free_ok_c;
  logic [NodeW-1:0]       mark_val_c;
  logic [AddrW-1:0]       desc_next_c;
  logic [AddrW-1:0]       parent_c;
  logic [LvlW-1:0]        lvl_dec_c;
  logic                   out_free_c;

  assign size_c   = CalcW'(1) << klog_q;
  assign pool_c   = CalcW'(Pool);
  assign offset_c = CalcW'(offset_q);

  // an allocation needs a large enough free block and enough free pages
  assign alloc_ok_c = (klog_q <= LvlW'(PoolLog)) && (CalcW'(root_q) >= size_c) &&
                      (CalcW'(free_q) >= size_c);

  // a free must be aligned to its size and lie inside the pool
  assign free_ok_c = (klog_q <= LvlW'(PoolLog)) &&
                     ((offset_c & (size_c - CalcW'(1))) == '0) &&
                     ((offset_c + size_c) <= pool_c);

  // node covering the freed block at its own level
  assign free_node_c = (pool_c >> klog_q) + (offset_c >> klog_q);

  assign mark_val_c  = (kind_q == bta_pkg::KindFree) ? size_c[NodeW-1:0] : '0;
  assign desc_next_c = {node_q[AddrW-2:0], ~alu_left_fits};
  assign parent_c    = node_q >> 1;
  assign lvl_dec_c   = lvl_q - LvlW'(1);
  assign free_sum_c  = CalcW'(free_q) + size_c;
  assign out_free_c  = !out_valid_q || out_ready_i;

  // on the way down the read data is always the left child; on the way up
  // the children are ordered by the parity of the node that was just written
  assign alu_left        = (node_q[0] || (state_q == StDesc)) ? ram_rdata : cur_val_q;
  assign alu_right       = node_q[0] ? cur_val_q : ram_rdata;
  assign alu_parent_size = NodeW'(CalcW'(1) << (lvl_q + LvlW'(1)));

  bta_node_alu #(
    .NodeW (NodeW),
    .CalcW (CalcW)
  ) u_alu (
    .left_i        (alu_left),
    .right_i       (alu_right),
    .parent_size_i (alu_parent_size),
    .full_merge_i  (kind_q == bta_pkg::KindFree),
    .need_i        (size_c),
    .merged_o      (alu_merged),
    .left_fits_o   (alu_left_fits)
  );

  bta_ram #(
    .Width (NodeW),
    .Depth (Depth)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    klog_d      = klog_q;
    offset_d    = offset_q;
    node_d      = node_q;
    lvl_d       = lvl_q;
    blk_off_d   = blk_off_q;
    cur_val_d   = cur_val_q;
    ok_d        = ok_q;
    free_d      = free_q;
    root_d      = root_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = cur_val_q;
    ram_raddr   = node_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // initialisation sweep: node n holds its subtree span
      StInit: begin
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = cur_val_q;
        if (node_q == AddrW'(Depth - 1)) begin
          state_d = StIdle;
        end else begin
          node_d = node_q + AddrW'(1);
          if (((node_q + AddrW'(1)) & node_q) == '0) begin
            cur_val_d = cur_val_q >> 1;
          end
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          kind_d   = in_data_i.kind;
          klog_d   = LvlW'(size_log(in_data_i.pages));
          offset_d = in_data_i.offset;
          state_d  = StCheck;
        end
      end
      StCheck: begin
        if (kind_q == bta_pkg::KindAlloc) begin
          blk_off_d = '0;
          node_d    = AddrW'(1);
          lvl_d     = LvlW'(PoolLog);
          if (!alloc_ok_c) begin
            ok_d    = 1'b0;
            state_d = StDone;
          end else if (klog_q == LvlW'(PoolLog)) begin
            state_d = StMark;
          end else begin
            ram_raddr = AddrW'(2);
            state_d   = StDesc;
          end
        end else begin
          blk_off_d = OffW'(offset_q);
          if (!free_ok_c) begin
            ok_d    = 1'b0;
            state_d = StDone;
          end else begin
            node_d    = free_node_c[AddrW-1:0];
            lvl_d     = klog_q;
            ram_raddr = free_node_c[AddrW-1:0];
            state_d   = StFreeChk;
          end
        end
      end
      // one level per cycle, read data is the left child of node_q
      StDesc: begin
        node_d = desc_next_c;
        lvl_d  = lvl_dec_c;
        if (!alu_left_fits) begin
          blk_off_d = blk_off_q + (OffW'(1) << lvl_dec_c);
        end
        if (lvl_dec_c == klog_q) begin
          state_d = StMark;
        end else begin
          ram_raddr = {desc_next_c[AddrW-2:0], 1'b0};
        end
      end
      // only a node marked used may be freed
      StFreeChk: begin
        if (ram_rdata == '0) begin
          state_d = StMark;
        end else begin
          ok_d    = 1'b0;
          state_d = StDone;
        end
      end
      StMark: begin
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = mark_val_c;
        cur_val_d = mark_val_c;
        ok_d      = 1'b1;
        if (kind_q == bta_pkg::KindAlloc) begin
          free_d = free_q - size_c[NodeW-1:0];
        end else if (free_sum_c > pool_c) begin
          free_d = pool_c[NodeW-1:0];
        end else begin
          free_d = free_sum_c[NodeW-1:0];
        end
        if (node_q == AddrW'(1)) begin
          root_d  = mark_val_c;
          state_d = StDone;
        end else begin
          ram_raddr = node_q ^ AddrW'(1);
          state_d   = StUp;
        end
      end
      // read data is the sibling, the written child comes from cur_val_q
      StUp: begin
        ram_we    = 1'b1;
        ram_waddr = parent_c;
        ram_wdata = alu_merged;
        cur_val_d = alu_merged;
        node_d    = parent_c;
        lvl_d     = lvl_q + LvlW'(1);
        if (parent_c == AddrW'(1)) begin
          root_d  = alu_merged;
          state_d = StDone;
        end else begin
          ram_raddr = parent_c ^ AddrW'(1);
        end
      end
      StDone: begin
        if (out_free_c) begin
          out_valid_d        = 1'b1;
          out_d.ok           = ok_q;
          out_d.block_offset = blk_off_q[bta_pkg::OffsetW-1:0];
          out_d.block_pages  = size_c[bta_pkg::PagesW-1:0];
          out_d.free_count   = bta_pkg::PagesW'(free_q);
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      node_q      <= AddrW'(1);
      cur_val_q   <= NodeW'(Pool);
      free_q      <= NodeW'(Pool);
      root_q      <= NodeW'(Pool);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      cur_val_q   <= cur_val_d;
      free_q      <= free_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    klog_q    <= klog_d;
    offset_q  <= offset_d;
    lvl_q     <= lvl_d;
    blk_off_q <= blk_off_d;
    ok_q      <= ok_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/bta_ram.sv
module bta_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bta_node_alu.sv
module bta_node_alu #(
  parameter int unsigned NodeW = 11,
  parameter int unsigned CalcW = 13
) (
  input  logic [NodeW-1:0] left_i,
  input  logic [NodeW-1:0] right_i,
  input  logic [NodeW-1:0] parent_size_i,
  input  logic             full_merge_i,
  input  logic [CalcW-1:0] need_i,
  output logic [NodeW-1:0] merged_o,
  output logic             left_fits_o
);

  logic [NodeW:0]   sum;
  logic [NodeW-1:0] larger;

  // buddy merge on a free: two fully free halves make one free parent; otherwise the parent holds the larger child
  assign sum    = {1'b0, left_i} + {1'b0, right_i};
  assign larger = (left_i > right_i) ? left_i : right_i;

  always_comb begin
    if (full_merge_i && (sum == {1'b0, parent_size_i})) begin
      merged_o = parent_size_i;
    end else begin
      merged_o = larger;
    end
  end

  // descent step: does the left child hold a large enough block
  assign left_fits_o = (CalcW'(left_i) >= need_i);

endmodule

>>> rtl/bta_checker.sv
module bta_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input bta_pkg::bta_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input bta_pkg::bta_out_t out_data_o
);

  // a waiting result holds until taken
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a transaction is in progress");

  // a new result follows a busy cycle
  a_result_after_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // every granted or released block is aligned to its size
  a_block_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ok |->
      ((11'(out_data_o.block_offset) & (out_data_o.block_pages - 11'd1)) == 11'd0))
    else $error("block offset not aligned to block size");

endmodule

bind buddy_tree_page_allocator bta_checker u_bta_checker (.*);
